[rtl/pte_pkg.sv]
// Shared types and codes for the piece table segment engine.
`default_nettype none
package pte_pkg;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
        logic [15:0] id;
        logic [31:0] off;
    } t_piece;

    localparam logic [2:0] OP_INSERT    = 3'd0;
    localparam logic [2:0] OP_DELETE    = 3'd1;
    localparam logic [2:0] OP_OVERWRITE = 3'd2;
    localparam logic [2:0] OP_READ      = 3'd3;
    localparam logic [2:0] OP_CLEAR     = 3'd4;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

endpackage
`default_nettype wire

[rtl/pte_ram.sv]
// Piece entry memory: one write port, one registered read port.
`default_nettype none
module pte_ram #(
    parameter int ADDR_W = 9
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [ADDR_W-1:0]   i_waddr,
    input  wire pte_pkg::t_piece     i_wdata,
    input  wire logic                i_re,
    input  wire logic [ADDR_W-1:0]   i_raddr,
    output pte_pkg::t_piece          o_rdata
);
    import pte_pkg::*;

    t_piece r_mem [2**ADDR_W];
    t_piece r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[rtl/piece_table_segment_engine_core.sv]
// Top level of the piece table segment engine: sequencer and result register.
//
// Usage:
//   Input channel i_in_valid / o_in_stall carries one item (op, edit offset,
//   edit length, change id, entry index). Output channel o_out_valid /
//   i_out_stall returns exactly one result item per input item.
//   i_cfg_we / i_cfg_wdata write base_length, used by the clear op.
// Sequencing, from the accepting edge to o_out_valid:
//   Clear and rejected items go from S_EXEC to S_FINISH; read passes S_RQ.
//   Insert, delete and overwrite stream every stored piece from the active
//   bank into the other through S_RD, S_HEAD, S_INS and S_TAIL, then S_TEND
//   and S_COMMIT. The memory has one read port and one write per cycle.
// Flow:
//   One item at a time; o_in_stall is high while an item is in work and the
//   next item is taken in the cycle after the previous result is loaded.
// Reset:
//   Synchronous, active low. The table is empty and base_length is zero.
//   No memory clearing pass is needed.
// Stall:
//   While i_out_stall holds a result, a further finished item waits in
//   its last state until the output register frees.
`default_nettype none
module piece_table_segment_engine_core #(
    parameter int MAX_PIECES = 256,
    localparam int CW = $clog2(MAX_PIECES + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [31:0]   i_cfg_wdata,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [2:0]    i_op,
    input  wire logic [31:0]   i_edit_offset,
    input  wire logic [31:0]   i_edit_length,
    input  wire logic [15:0]   i_change_id,
    input  wire logic [7:0]    i_entry_index,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [1:0]         o_status,
    output logic               o_entry_valid,
    output logic [31:0]        o_entry_start,
    output logic [31:0]        o_entry_length,
    output logic [15:0]        o_entry_source_id,
    output logic [31:0]        o_entry_source_offset,
    output logic [CW-1:0]      o_piece_count,
    output logic [31:0]        o_content_size
);
    import pte_pkg::*;

    localparam int AW = $clog2(MAX_PIECES);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_EXEC   = 10'b0000000010,
        S_RQ     = 10'b0000000100,
        S_RD     = 10'b0000001000,
        S_HEAD   = 10'b0000010000,
        S_INS    = 10'b0000100000,
        S_TAIL   = 10'b0001000000,
        S_TEND   = 10'b0010000000,
        S_COMMIT = 10'b0100000000,
        S_FINISH = 10'b1000000000
    } t_state;

    t_state        r_state;
    logic [31:0]   r_base;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_total;
    logic          r_bank;

    logic [2:0]    r_op;
    logic [31:0]   r_eo;
    logic [31:0]   r_el;
    logic [15:0]   r_id;
    logic [7:0]    r_idx;
    logic [31:0]   r_ed;
    logic          r_ins;
    logic          r_ins_done;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_w;
    logic [31:0]   r_acc;
    logic          r_ovf;
    logic [31:0]   r_e;
    logic [31:0]   r_offb;
    logic [1:0]    r_st;

    logic          r_evalid;
    logic [31:0]   r_es;
    logic [31:0]   r_elen;
    logic [15:0]   r_eid;
    logic [31:0]   r_eoff;

    logic          r_ov;
    logic [1:0]    r_o_status;
    logic          r_o_evalid;
    logic [31:0]   r_o_es;
    logic [31:0]   r_o_elen;
    logic [15:0]   r_o_eid;
    logic [31:0]   r_o_eoff;
    logic [CW-1:0] r_o_pc;
    logic [31:0]   r_o_cs;

    t_piece        ram_q;
    logic          ram_we;
    logic [AW:0]   ram_waddr;
    t_piece        ram_wdata;
    logic          ram_re;
    logic [AW:0]   ram_raddr;

    logic          wr_req;
    logic [31:0]   wr_len;
    logic [31:0]   wr_off;
    logic [15:0]   wr_id;
    logic          w_full;

    logic [31:0]   room;
    logic [31:0]   ed_new;
    logic [32:0]   ins_sum;
    logic [32:0]   ovw_sum;
    logic          rej_ins;
    logic          rej_del;
    logic          rej_ovw;
    logic [31:0]   e_end;
    logic [31:0]   head_len;
    logic [31:0]   tail_ts;
    logic          out_free;
    logic          idx_ok;

    pte_ram #(.ADDR_W(AW + 1)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign room    = r_total - r_eo;
    assign ed_new  = (r_el < room) ? (r_eo + r_el) : r_total;
    assign ins_sum = {1'b0, r_total} + {1'b0, r_el};
    assign ovw_sum = {1'b0, r_eo} + {1'b0, r_el};
    assign rej_ins = (r_el == '0) || (r_eo > r_total) || ins_sum[32];
    assign rej_del = (r_el == '0) || (r_eo >= r_total);
    assign rej_ovw = (r_el == '0) || (r_eo > r_total) || ovw_sum[32];

    assign e_end    = ram_q.start + ram_q.len;
    assign head_len = (e_end <= r_eo) ? ram_q.len : (r_eo - ram_q.start);
    assign tail_ts  = (ram_q.start > r_ed) ? ram_q.start : r_ed;
    assign w_full   = (r_w == CW'(MAX_PIECES));
    assign out_free = !r_ov || !i_out_stall;
    assign idx_ok   = 32'(r_idx) < 32'(r_cnt);

    // Select the piece produced this cycle, if any
    always_comb begin
        wr_req = 1'b0;
        wr_len = '0;
        wr_off = '0;
        wr_id  = '0;
        unique case (r_state)
            S_HEAD: begin
                if (ram_q.start < r_eo) begin
                    wr_req = 1'b1;
                    wr_len = head_len;
                    wr_off = ram_q.off;
                    wr_id  = ram_q.id;
                end
            end
            S_INS: begin
                if (r_ins && !r_ins_done && (r_e > r_eo)) begin
                    wr_req = 1'b1;
                    wr_len = r_el;
                    wr_id  = r_id;
                end
            end
            S_TAIL: begin
                if (r_e > r_ed) begin
                    wr_req = 1'b1;
                    wr_len = r_e - tail_ts;
                    wr_off = r_offb + tail_ts;
                    wr_id  = ram_q.id;
                end
            end
            S_TEND: begin
                if (r_ins && !r_ins_done) begin
                    wr_req = 1'b1;
                    wr_len = r_el;
                    wr_id  = r_id;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {~r_bank, AW'(r_w)};
        ram_wdata = '{start: r_acc, len: wr_len, id: wr_id, off: wr_off};
        if (wr_req && !w_full) begin
            ram_we = 1'b1;
        end else if (r_state == S_EXEC && r_op == OP_CLEAR && r_base != '0) begin
            ram_we    = 1'b1;
            ram_waddr = {r_bank, AW'(0)};
            ram_wdata = '{start: 32'd0, len: r_base, id: 16'd0, off: 32'd0};
        end
    end

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = {r_bank, AW'(r_j)};
        if (r_state == S_EXEC && r_op == OP_READ) begin
            ram_re    = 1'b1;
            ram_raddr = {r_bank, AW'(r_idx)};
        end else if (r_state == S_RD && r_j != r_cnt) begin
            ram_re = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= '0;
            r_cnt   <= '0;
            r_total <= '0;
            r_bank  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (r_state == S_FINISH && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_op)
                        OP_INSERT:    r_state <= rej_ins ? S_FINISH : S_RD;
                        OP_DELETE:    r_state <= rej_del ? S_FINISH : S_RD;
                        OP_OVERWRITE: r_state <= rej_ovw ? S_FINISH : S_RD;
                        OP_READ:      r_state <= S_RQ;
                        OP_CLEAR: begin
                            r_cnt   <= (r_base != '0) ? CW'(1) : '0;
                            r_total <= r_base;
                            r_state <= S_FINISH;
                        end
                        default:      r_state <= S_FINISH;
                    endcase
                end
                S_RQ:   r_state <= S_FINISH;
                S_RD:   r_state <= (r_j == r_cnt) ? S_TEND : S_HEAD;
                S_HEAD: r_state <= S_INS;
                S_INS:  r_state <= S_TAIL;
                S_TAIL: r_state <= S_RD;
                S_TEND: r_state <= S_COMMIT;
                S_COMMIT: begin
                    // swap banks only when the rebuilt table fits
                    if (!r_ovf) begin
                        r_bank  <= ~r_bank;
                        r_cnt   <= r_w;
                        r_total <= r_acc;
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_op  <= i_op;
            r_eo  <= i_edit_offset;
            r_el  <= i_edit_length;
            r_id  <= i_change_id;
            r_idx <= i_entry_index;
        end
        if (r_state == S_EXEC) begin
            r_evalid   <= 1'b0;
            r_es       <= '0;
            r_elen     <= '0;
            r_eid      <= '0;
            r_eoff     <= '0;
            r_j        <= '0;
            r_w        <= '0;
            r_acc      <= '0;
            r_ovf      <= 1'b0;
            r_ins_done <= 1'b0;
            r_ins      <= (r_op != OP_DELETE);
            r_ed       <= (r_op == OP_INSERT) ? r_eo : ed_new;
            case (r_op)
                OP_INSERT:    r_st <= rej_ins ? ST_REJECT : ST_DONE;
                OP_DELETE:    r_st <= rej_del ? ST_REJECT : ST_DONE;
                OP_OVERWRITE: r_st <= rej_ovw ? ST_REJECT : ST_DONE;
                OP_READ:      r_st <= ST_DONE;
                OP_CLEAR:     r_st <= ST_DONE;
                default:      r_st <= ST_REJECT;
            endcase
        end
        if (r_state == S_RQ && idx_ok) begin
            r_evalid <= 1'b1;
            r_es     <= ram_q.start;
            r_elen   <= ram_q.len;
            r_eid    <= ram_q.id;
            r_eoff   <= ram_q.off;
        end
        if (r_state == S_HEAD) begin
            r_e    <= e_end;
            r_offb <= ram_q.off - ram_q.start;
        end
        if (r_state == S_INS || r_state == S_TEND) begin
            r_ins_done <= r_ins_done | wr_req;
        end
        if (r_state == S_TAIL) begin
            r_j <= r_j + CW'(1);
        end
        if (wr_req) begin
            // drop the piece that would not fit and flag the table full
            if (w_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_w   <= r_w + CW'(1);
                r_acc <= r_acc + wr_len;
            end
        end
        if (r_state == S_COMMIT && r_ovf) begin
            r_st <= ST_FULL;
        end
        if (r_state == S_FINISH && out_free) begin
            r_o_status <= r_st;
            r_o_evalid <= r_evalid;
            r_o_es     <= r_es;
            r_o_elen   <= r_elen;
            r_o_eid    <= r_eid;
            r_o_eoff   <= r_eoff;
            r_o_pc     <= r_cnt;
            r_o_cs     <= r_total;
        end
    end

    assign o_in_stall            = (r_state != S_IDLE);
    assign o_out_valid           = r_ov;
    assign o_status              = r_o_status;
    assign o_entry_valid         = r_o_evalid;
    assign o_entry_start         = r_o_es;
    assign o_entry_length        = r_o_elen;
    assign o_entry_source_id     = r_o_eid;
    assign o_entry_source_offset = r_o_eoff;
    assign o_piece_count         = r_o_pc;
    assign o_content_size        = r_o_cs;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MAX_PIECES)
        else $error("piece count above table size");

    a_walk_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state != S_EXEC) |-> (ram_waddr[AW] != r_bank))
        else $error("rebuild wrote into the active bank");

    a_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && !r_ovf) |=> (r_bank != $past(r_bank)))
        else $error("bank not swapped after commit");

    a_full_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && r_ovf) |=> (r_cnt == $past(r_cnt)))
        else $error("full table changed piece count");

endmodule
`default_nettype wire
